// ----- hdl/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Button press classifier package
// Register indexes, register widths and reset values shared by the design.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Configuration port geometry
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_IDLE_LEVEL   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FILTER_TICKS = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_TICKS   = 2'd2;

  // Threshold register width
  localparam int TICKS_WIDTH = 16;

  // Reset values of the registers
  localparam logic                   IDLE_LEVEL_RESET   = 1'b1;
  localparam logic [TICKS_WIDTH-1:0] FILTER_TICKS_RESET = 16'd5;
  localparam logic [TICKS_WIDTH-1:0] LONG_TICKS_RESET   = 16'd100;

  // Default counter width
  localparam int COUNT_WIDTH_DEFAULT = 16;

endpackage

// ----- hdl/button_press_classifier.sv -----
// ----------------------------------------------------------------------------
// Button press classifier
// Debounces a sampled push-button level and reports short press, long press
// and release as flags of a result, one result transaction per input transaction.
// ----------------------------------------------------------------------------
// The result of a pin sample is registered and appears in the cycle after it is accepted.
// Throughput: one sample per cycle; the phase update and both counter
// compares sit in one level of logic ahead of the state and result registers.
// A waiting result does not stop the next sample while out_ready is high.
// Reset (synchronous, rst high): phase idle, counters cleared, button taken as
// not pressed, registers at idle level 1, filter 5 ticks, long press 100 ticks.
module button_press_classifier #(
  parameter int COUNT_WIDTH = bpc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Sample channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 pin_level,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 short_press,
  output logic                                 long_press,
  output logic                                 released,
  // Configuration write port
  input  logic                                 cfg_write,
  input  logic [bpc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [bpc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  // Phase codes
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_FILTER     = 3'd1;
  localparam logic [2:0] PH_SHORT      = 3'd2;
  localparam logic [2:0] PH_SHORT_HOLD = 3'd3;
  localparam logic [2:0] PH_LONG       = 3'd4;
  localparam logic [2:0] PH_LONG_HOLD  = 3'd5;
  localparam logic [2:0] PH_RELEASE    = 3'd6;

  // Compare width covers both the counters and the threshold registers
  localparam int CMP_WIDTH = (COUNT_WIDTH > bpc_pkg::TICKS_WIDTH) ?
                             COUNT_WIDTH : bpc_pkg::TICKS_WIDTH;

  logic                            idle_level;
  logic [bpc_pkg::TICKS_WIDTH-1:0] filter_ticks;
  logic [bpc_pkg::TICKS_WIDTH-1:0] long_ticks;

  logic [2:0]             phase;
  logic [2:0]             phase_next;
  logic [COUNT_WIDTH-1:0] filter_count;
  logic [COUNT_WIDTH-1:0] filter_count_next;
  logic [COUNT_WIDTH-1:0] hold_count;
  logic [COUNT_WIDTH-1:0] hold_count_next;
  logic                   was_pressed;

  logic                   pressed;
  logic                   in_fire;
  logic [COUNT_WIDTH-1:0] filter_inc;
  logic [COUNT_WIDTH-1:0] hold_inc;
  logic                   filter_reached;
  logic                   hold_reached;
  logic                   sp_next;
  logic                   lp_next;
  logic                   rl_next;

  // Handshake: the result register frees itself when taken in the same cycle
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_level   <= bpc_pkg::IDLE_LEVEL_RESET;
      filter_ticks <= bpc_pkg::FILTER_TICKS_RESET;
      long_ticks   <= bpc_pkg::LONG_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bpc_pkg::REG_IDLE_LEVEL:   idle_level   <= cfg_data[0];
        bpc_pkg::REG_FILTER_TICKS: filter_ticks <= cfg_data[bpc_pkg::TICKS_WIDTH-1:0];
        bpc_pkg::REG_LONG_TICKS:   long_ticks   <= cfg_data[bpc_pkg::TICKS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Pressed is any level other than the idle level
  assign pressed = (pin_level != idle_level);

  // Saturating increments of both counters
  assign filter_inc = (&filter_count) ? filter_count : filter_count + 1'b1;
  assign hold_inc   = (&hold_count) ? hold_count : hold_count + 1'b1;

  // Threshold compares use the counts after this sample's increment
  assign filter_reached =
    CMP_WIDTH'(pressed ? filter_inc : filter_count) >= CMP_WIDTH'(filter_ticks);
  assign hold_reached =
    CMP_WIDTH'(pressed ? hold_inc : hold_count) >= CMP_WIDTH'(long_ticks);

  // Phase machine; a reached threshold overrides a release in the same tick
  always_comb begin
    phase_next        = phase;
    filter_count_next = filter_count;
    hold_count_next   = hold_count;
    sp_next           = 1'b0;
    lp_next           = 1'b0;
    rl_next           = 1'b0;
    unique case (phase)
      PH_FILTER: begin
        if (pressed) begin
          filter_count_next = filter_inc;
        end else begin
          phase_next = PH_IDLE;
        end
        if (filter_reached) begin
          phase_next = PH_SHORT;
        end
      end
      PH_SHORT: begin
        sp_next    = 1'b1;
        phase_next = PH_SHORT_HOLD;
      end
      PH_SHORT_HOLD: begin
        if (pressed) begin
          hold_count_next = hold_inc;
        end else begin
          phase_next = PH_RELEASE;
        end
        if (hold_reached) begin
          phase_next = PH_LONG;
        end
      end
      PH_LONG: begin
        lp_next    = 1'b1;
        phase_next = PH_LONG_HOLD;
      end
      PH_LONG_HOLD: begin
        if (!pressed) begin
          phase_next = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        rl_next    = 1'b1;
        phase_next = PH_IDLE;
      end
      default: begin
        // Idle, and the unused code, wait for a fresh press
        filter_count_next = '0;
        hold_count_next   = '0;
        phase_next        = (pressed && !was_pressed) ? PH_FILTER : PH_IDLE;
      end
    endcase
  end

  // State registers advance once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      filter_count <= '0;
      hold_count   <= '0;
      was_pressed  <= 1'b0;
    end else if (in_fire) begin
      phase        <= phase_next;
      filter_count <= filter_count_next;
      hold_count   <= hold_count_next;
      was_pressed  <= pressed;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      short_press <= sp_next;
      long_press  <= lp_next;
      released    <= rl_next;
    end
  end

  // At most one report per result
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({short_press, long_press, released}))
    else $error("more than one report flag set in a result");

  // A sample taken in the short press phase reports a short press
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PH_SHORT) |=> (out_valid && short_press))
    else $error("short press phase did not report a short press");

  // Leaving idle always starts with cleared counters
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PH_IDLE) |=> (filter_count == '0 && hold_count == '0))
    else $error("counters not cleared in idle");

  // An empty result register never blocks the sample channel
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("sample channel stalled with empty result register");

endmodule
